>>> design/c_comment_strip_line_splice_core_assert.svh
// assertion macros used by the checker file of the comment stripper
// no dependencies; clk_i and rst_ni must be visible where a macro is used
`ifndef C_COMMENT_STRIP_LINE_SPLICE_CORE_ASSERT_SVH
`define C_COMMENT_STRIP_LINE_SPLICE_CORE_ASSERT_SVH

// checked only while out of reset
`define CCSLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CCSLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/ccsls_pkg.sv
// types, character constants and scan step functions for the comment stripper
// no dependencies; used by ccsls_scan, ccsls_outq and the top level
package ccsls_pkg;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;

  localparam logic [1:0] FLT_NONE    = 2'd0;
  localparam logic [1:0] FLT_UNTERM  = 2'd1;
  localparam logic [1:0] FLT_LONG    = 2'd2;
  localparam logic [1:0] FLT_INVALID = 2'd3;

  localparam logic [15:0] MAX_LEN_RST = 16'd4094;
  localparam logic [1:0]  MAX_RES     = 2'd3;

  typedef enum logic [5:0] {
    M_NORMAL = 6'b000001,
    M_SLASH  = 6'b000010,
    M_PAIR   = 6'b000100,
    M_BLOCK  = 6'b001000,
    M_BSTAR  = 6'b010000,
    M_LINE   = 6'b100000
  } mode_e;

  typedef enum logic [2:0] {
    Q_NONE   = 3'b001,
    Q_SINGLE = 3'b010,
    Q_DOUBLE = 3'b100
  } quote_e;

  typedef struct packed {
    mode_e       mode;
    quote_e      quote;
    logic [15:0] len;
  } scan_t;

  typedef struct packed {
    logic       eos;
    logic [1:0] fault;
    logic       last;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    scan_t          st;
    logic [1:0]     n;
    res_t [2:0]     r;
  } step_t;

  // results of one processed beat, all sharing one line number
  typedef struct packed {
    logic [1:0]  n;
    logic [31:0] line;
    res_t [2:0]  r;
  } push_t;

  typedef struct packed {
    logic [31:0] line;
    res_t        r;
  } entry_t;

  function automatic logic is_printable(logic [7:0] b);
    logic ok;
    ok = ((b >= 8'h20) && (b <= 8'h7E)) || ((b >= 8'h09) && (b <= 8'h0D));
    return ok;
  endfunction

  function automatic step_t put_f(step_t s, res_t r);
    step_t t;
    t = s;
    if (t.n < MAX_RES) begin
      t.r[t.n] = r;
      t.n      = t.n + 2'd1;
    end
    return t;
  endfunction

  function automatic res_t mk_res(logic [7:0] d, logic last, logic [1:0] f, logic eos);
    res_t r;
    r.data  = d;
    r.last  = last;
    r.fault = f;
    r.eos   = eos;
    return r;
  endfunction

  function automatic step_t end_line_f(step_t s);
    step_t t;
    t = put_f(s, mk_res(CH_NL, 1'b1, FLT_NONE, 1'b0));
    t.st.len   = 16'd0;
    t.st.quote = Q_NONE;
    t.st.mode  = M_NORMAL;
    return t;
  endfunction

  // cap is the content limit, max_line_length - 1
  function automatic step_t emit_f(step_t s, logic [7:0] c, logic [1:0] f,
                                   logic [15:0] cap);
    step_t t;
    t = s;
    if (t.st.len >= cap) begin
      t = put_f(t, mk_res(CH_NL, 1'b1, FLT_LONG, 1'b0));
      t.st.len   = 16'd0;
      t.st.quote = Q_NONE;
      t.st.mode  = M_NORMAL;
    end else begin
      t = put_f(t, mk_res(c, 1'b0, f, 1'b0));
      t.st.len = t.st.len + 16'd1;
    end
    return t;
  endfunction

  // one logical character through the mode machine
  function automatic step_t logical_f(step_t s, logic [7:0] c, logic [1:0] f,
                                      logic [15:0] cap);
    step_t t;
    logic  go;
    t  = s;
    go = 1'b1;
    case (t.st.mode)
      M_LINE: begin
        go = 1'b0;
        if (c == CH_NL) t = end_line_f(t);
      end
      M_BLOCK: begin
        go = 1'b0;
        if (c == CH_STAR) t.st.mode = M_BSTAR;
      end
      M_BSTAR: begin
        go = 1'b0;
        if (c == CH_SLASH) begin
          t.st.mode = M_NORMAL;
          t = emit_f(t, CH_SPACE, FLT_NONE, cap);
        end else if (c != CH_STAR) begin
          t.st.mode = M_BLOCK;
        end
      end
      M_PAIR: begin
        go = 1'b0;
        if (c == CH_NL) begin
          t = end_line_f(t);
        end else begin
          t.st.mode = M_NORMAL;
          t = emit_f(t, c, f, cap);
        end
      end
      M_SLASH: begin
        if (c == CH_STAR) begin
          go = 1'b0;
          t.st.mode = M_BLOCK;
        end else if (c == CH_SLASH) begin
          go = 1'b0;
          t.st.mode = M_LINE;
        end else begin
          t.st.mode = M_NORMAL;
          t = emit_f(t, CH_SLASH, FLT_NONE, cap);
        end
      end
      default: t.st.mode = M_NORMAL;
    endcase

    if (go) begin
      if (c == CH_NL) begin
        t = end_line_f(t);
      end else if (c == CH_BSL) begin
        t.st.mode = M_PAIR;
        t = emit_f(t, c, f, cap);
      end else if ((c == CH_SLASH) && (t.st.quote == Q_NONE)) begin
        t.st.mode = M_SLASH;
      end else begin
        if ((t.st.quote == Q_SINGLE) && (c == CH_SQ)) t.st.quote = Q_NONE;
        else if ((t.st.quote == Q_DOUBLE) && (c == CH_DQ)) t.st.quote = Q_NONE;
        else if ((t.st.quote == Q_NONE) && (c == CH_SQ)) t.st.quote = Q_SINGLE;
        else if ((t.st.quote == Q_NONE) && (c == CH_DQ)) t.st.quote = Q_DOUBLE;
        t = emit_f(t, c, f, cap);
      end
    end
    return t;
  endfunction

endpackage

>>> design/ccsls_scan.sv
// input register, scan state and the per-beat step logic of the comment stripper
// depends on ccsls_pkg; feeds up to three results a beat into ccsls_outq
module ccsls_scan
  import ccsls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [7:0]  s_byte_i,
  input  logic        s_eoi_i,
  input  logic [15:0] cap_i,
  input  logic        room_i,
  output push_t       push_o
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_eoi_q;
  scan_t       st_q, st_d;
  logic        bs_q, bs_d;
  logic [31:0] lc_q, lc_d;
  logic [31:0] line_num;
  logic        proc;
  logic        is_nl;
  logic [1:0]  flt;
  logic [1:0]  unterm;
  step_t       s;

  assign proc      = in_valid_q && room_i;
  assign s_ready_o = !in_valid_q || room_i;

  always_comb begin
    s.st     = st_q;
    s.n      = 2'd0;
    s.r      = '0;
    bs_d     = bs_q;
    lc_d     = lc_q;
    line_num = lc_q;
    unterm   = FLT_NONE;
    is_nl    = (in_byte_q == CH_NL);
    flt      = is_printable(in_byte_q) ? FLT_NONE : FLT_INVALID;

    if (in_eoi_q) begin
      // release held characters, then the closing newline
      if (bs_q) s = logical_f(s, CH_BSL, FLT_NONE, cap_i);
      if (s.st.mode == M_SLASH) begin
        s.st.mode = M_NORMAL;
        s = emit_f(s, CH_SLASH, FLT_NONE, cap_i);
      end
      if ((s.st.mode == M_BLOCK) || (s.st.mode == M_BSTAR) || (s.st.mode == M_LINE))
        unterm = FLT_UNTERM;
      s = put_f(s, mk_res(CH_NL, 1'b1, unterm, 1'b1));
      s.st.mode  = M_NORMAL;
      s.st.quote = Q_NONE;
      s.st.len   = 16'd0;
      bs_d       = 1'b0;
      lc_d       = 32'd0;
    end else begin
      if (is_nl) lc_d = lc_q + 32'd1;
      line_num = lc_d;
      if (bs_q && is_nl) begin
        // splice: backslash and newline vanish
        bs_d = 1'b0;
      end else begin
        if (bs_q) s = logical_f(s, CH_BSL, FLT_NONE, cap_i);
        if (in_byte_q == CH_BSL) begin
          bs_d = 1'b1;
        end else begin
          bs_d = 1'b0;
          s = logical_f(s, in_byte_q, flt, cap_i);
        end
      end
    end
    st_d = s.st;
  end

  always_comb begin
    push_o.n    = proc ? s.n : 2'd0;
    push_o.line = line_num;
    push_o.r    = s.r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q.mode  <= M_NORMAL;
      st_q.quote <= Q_NONE;
      st_q.len   <= 16'd0;
      bs_q       <= 1'b0;
      lc_q       <= 32'd0;
    end else begin
      if (s_ready_o) in_valid_q <= s_valid_i;
      if (proc) begin
        st_q <= st_d;
        bs_q <= bs_d;
        lc_q <= lc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      in_byte_q <= s_byte_i;
      in_eoi_q  <= s_eoi_i;
    end
  end

endmodule

>>> design/ccsls_outq.sv
// four-entry result queue: takes up to three results a cycle, hands out one a beat
// depends on ccsls_pkg; drives the master stream of the top level
module ccsls_outq
  import ccsls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  push_t       push_i,
  output logic        room_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser
);

  entry_t     mem_q [4];
  logic [1:0] wptr_q, wptr_d;
  logic [1:0] rptr_q, rptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;
  entry_t     head;

  assign head          = mem_q[rptr_q];
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (count_q != 3'd0);
  assign m_axis_tdata  = {head.line, head.r.data};
  assign m_axis_tlast  = head.r.last;
  assign m_axis_tuser  = {head.r.eos, head.r.fault};
  // a beat may bring three results
  assign room_o        = (count_q <= 3'd1);

  always_comb begin
    wptr_d  = wptr_q + push_i.n;
    rptr_d  = rptr_q + {1'b0, pop};
    count_d = count_q + {1'b0, push_i.n} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 2'd0;
      rptr_q  <= 2'd0;
      count_q <= 3'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_i.n) begin
        mem_q[wptr_q + 2'(i)] <= '{line: push_i.line, r: push_i.r[i]};
      end
    end
  end

endmodule

>>> design/c_comment_strip_line_splice_core.sv
// C comment stripper with line splicing: raw source bytes in, logical lines out
// Channels: s_axis takes one raw byte a beat (tuser[0] marks end of input, byte
// ignored). m_axis gives one byte of the cleaned line a beat, tlast on the
// newline that ends a line, the physical line number in tdata[39:8], the fault
// code and the end-of-stream flag in tuser. cfg_* writes max_line_length.
// Path: each byte passes the input register, then the step logic into the
// output queue, from which its results leave on m_axis.
// Throughput: one input byte a cycle while each byte gives at most one result
// and the receiver takes every beat; a byte that gives two or three results
// (released slash or backslash, end of input) holds the input until the output
// queue drains, as the four-entry queue takes a new byte only with one entry or less.
// Reset: all scan state, the line count and the queue clear; max_line_length
// returns to 4094. No clearing pass, input is taken right after reset.
// Receiver stall: the queue fills, the input register holds its byte and
// s_axis_tready drops until room returns. Nothing is lost or repeated.
// Write the register only while the block is idle.
// depends on ccsls_pkg, ccsls_scan and ccsls_outq
module c_comment_strip_line_splice_core
  import ccsls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic [0:0]  s_axis_tuser,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte, line_number
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser,   // fault, end_of_stream
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] cap_q, cap_d;
  logic        room;
  push_t       push;

  assign cfg_ready_o = 1'b1;

  // hold the content limit, values below two act as two
  assign cap_d = (cfg_data_i >= 16'd2) ? (cfg_data_i - 16'd1) : 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= MAX_LEN_RST - 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cap_d;
    end
  end

  ccsls_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_byte_i  (s_axis_tdata),
    .s_eoi_i   (s_axis_tuser[0]),
    .cap_i     (cap_q),
    .room_i    (room),
    .push_o    (push)
  );

  ccsls_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> design/ccsls_chk.sv
// port-level checks for the comment stripper, bound to the top level
// depends on c_comment_strip_line_splice_core_assert.svh
`include "c_comment_strip_line_splice_core_assert.svh"

module ccsls_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [2:0]  m_axis_tuser
);

  // stalled beat stays valid and keeps its tdata
  `CCSLS_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  // newline bytes are exactly the line ends
  `CCSLS_ASSERT(a_nl_last, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[7:0] == 8'h0A)), "tlast and newline disagree")
  // end of stream and unterminated comment only on a closing newline
  `CCSLS_ASSERT(a_eos_last, m_axis_tvalid && (m_axis_tuser[2] || m_axis_tuser[1:0] == 2'd1) |-> m_axis_tlast && m_axis_tuser[2], "end flag off a final newline")
  // invalid-byte fault only on a byte outside the accepted ranges
  `CCSLS_ASSERT(a_invalid, m_axis_tvalid && m_axis_tuser[1:0] == 2'd3 |-> !m_axis_tlast && (m_axis_tdata[7:0] < 8'h09 || m_axis_tdata[7:0] > 8'h7E || (m_axis_tdata[7:0] > 8'h0D && m_axis_tdata[7:0] < 8'h20)), "invalid flag on a good byte")
  // no result follows a clock edge in reset; the queue clears asynchronously
  `CCSLS_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !m_axis_tvalid, "result during reset")

endmodule

bind c_comment_strip_line_splice_core ccsls_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
